// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

// ===== src/lkd_pkg.sv =====
package lkd_pkg;

	localparam int CLEAR_BYTES_DEF  = 16;
	localparam int SETTLE_TICKS_DEF = 10;

	localparam logic [1:0] FUNC_CMD  = 2'd0;
	localparam logic [1:0] FUNC_DATA = 2'd1;
	localparam logic [1:0] FUNC_KEYS = 2'd2;
	localparam logic [1:0] FUNC_INIT = 2'd3;

	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_START  = 4'd1;
	localparam logic [3:0] PH_BIT_LO = 4'd2;
	localparam logic [3:0] PH_BIT_HI = 4'd3;
	localparam logic [3:0] PH_STB_UP = 4'd4;
	localparam logic [3:0] PH_GAP    = 4'd5;
	localparam logic [3:0] PH_SETTLE = 4'd6;
	localparam logic [3:0] PH_KEY_LO = 4'd7;
	localparam logic [3:0] PH_KEY_HI = 4'd8;

	localparam logic [7:0] CMD_KEY_READ   = 8'h42;
	localparam logic [7:0] CMD_WRITE_FIX  = 8'h44;
	localparam logic [7:0] CMD_ADDR_BASE  = 8'hC0;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h8F;
	localparam logic [7:0] CMD_WRITE_AUTO = 8'h40;
	localparam logic [7:0] CLEAR_DATA     = 8'h00;

	localparam int KEY_GROUPS   = 8;
	localparam int KEY_BITS     = 3;
	localparam int KEY_WIDTH    = KEY_GROUPS * KEY_BITS;

	typedef struct packed {
		logic       req_valid;
		logic [1:0] func;
		logic [3:0] address;
		logic [7:0] data_byte;
		logic       di;
	} req_t;

	typedef struct packed {
		logic                 clk_pin;
		logic                 data_pin;
		logic                 strobe_pin;
		logic                 busy_res;
		logic                 keys_valid;
		logic [KEY_WIDTH-1:0] keys;
	} res_t;

	typedef struct packed {
		logic [3:0]           phase;
		logic [7:0]           tx_shift;
		logic [3:0]           bit_count;
		logic [4:0]           byte_count;
		logic [3:0]           wait_count;
		logic [KEY_WIDTH-1:0] key_shift;
		logic [1:0]           func;
		logic [3:0]           address;
		logic [7:0]           data_byte;
		logic                 pin_clk;
		logic                 pin_dat;
		logic                 pin_stb;
	} state_t;

	function automatic logic [7:0] byte_at(input logic [1:0] func, input logic [3:0] address,
			input logic [7:0] data_byte, input logic [4:0] k);
		logic [7:0] b;
		case (func)
			FUNC_CMD: b = data_byte;
			FUNC_DATA: begin
				if (k == 5'd0)
					b = CMD_WRITE_FIX;
				else if (k == 5'd1)
					b = CMD_ADDR_BASE | {4'd0, address};
				else
					b = data_byte;
			end
			FUNC_KEYS: b = CMD_KEY_READ;
			default: begin
				if (k == 5'd0)
					b = CMD_DISPLAY_ON;
				else if (k == 5'd1)
					b = CMD_WRITE_AUTO;
				else if (k == 5'd2)
					b = CMD_ADDR_BASE;
				else
					b = CLEAR_DATA;
			end
		endcase
		return b;
	endfunction

	function automatic logic gap_after(input logic [1:0] func, input logic [4:0] k);
		logic g;
		case (func)
			FUNC_CMD, FUNC_DATA: g = (k == 5'd0);
			FUNC_INIT: g = (k <= 5'd1);
			default: g = 1'b0;
		endcase
		return g;
	endfunction

endpackage

// ===== src/lkd_item_if.sv =====
interface lkd_item_if;
	import lkd_pkg::*;

	logic       valid;
	logic       ready;
	logic       req_valid;
	logic [1:0] func;
	logic [3:0] address;
	logic [7:0] data_byte;
	logic       di;

	modport source(output valid, output req_valid, output func, output address,
		output data_byte, output di, input ready);
	modport sink(input valid, input req_valid, input func, input address,
		input data_byte, input di, output ready);
endinterface

// ===== src/lkd_result_if.sv =====
interface lkd_result_if;
	import lkd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 clk_pin;
	logic                 data_pin;
	logic                 strobe_pin;
	logic                 busy_res;
	logic                 keys_valid;
	logic [KEY_WIDTH-1:0] keys;

	modport source(output valid, output clk_pin, output data_pin, output strobe_pin,
		output busy_res, output keys_valid, output keys, input ready);
	modport sink(input valid, input clk_pin, input data_pin, input strobe_pin,
		input busy_res, input keys_valid, input keys, output ready);
endinterface

// ===== src/lkd_step.sv =====
module lkd_step #(
	parameter int CLEAR_BYTES  = lkd_pkg::CLEAR_BYTES_DEF,
	parameter int SETTLE_TICKS = lkd_pkg::SETTLE_TICKS_DEF
) (
	input  lkd_pkg::state_t st,
	input  lkd_pkg::req_t   req,
	output lkd_pkg::state_t st_next,
	output lkd_pkg::res_t   res
);
	import lkd_pkg::*;

	localparam logic [4:0] LAST_CLEAR = 5'(2 + CLEAR_BYTES);
	localparam logic [3:0] SETTLE_END = 4'(SETTLE_TICKS);

	logic       last_byte;
	logic       gap;
	logic [4:0] byte_inc;
	logic [3:0] bit_inc;
	logic [3:0] wait_inc;
	logic [4:0] key_pos;
	logic       keys_done;

	always_comb begin
		case (st.func)
			FUNC_CMD: last_byte = (st.byte_count == 5'd0);
			FUNC_DATA: last_byte = (st.byte_count >= 5'd2);
			FUNC_INIT: last_byte = (st.byte_count >= LAST_CLEAR);
			default: last_byte = 1'b0;
		endcase
	end

	assign gap      = gap_after(st.func, st.byte_count);
	assign byte_inc = st.byte_count + 5'd1;
	assign bit_inc  = st.bit_count + 4'd1;
	assign wait_inc = st.wait_count + 4'd1;
	assign key_pos  = {1'b0, st.byte_count[2:0], 1'b0} + {2'b0, st.byte_count[2:0]}
		+ {3'b0, st.bit_count[1:0]};

	always_comb begin
		st_next   = st;
		keys_done = 1'b0;
		case (st.phase)
			PH_IDLE: begin
				if (req.req_valid) begin
					st_next.func       = req.func;
					st_next.address    = req.address;
					st_next.data_byte  = req.data_byte;
					st_next.byte_count = 5'd0;
					st_next.pin_stb    = 1'b0;
					st_next.tx_shift   = byte_at(req.func, req.address, req.data_byte, 5'd0);
					st_next.bit_count  = 4'd0;
					st_next.phase      = PH_BIT_LO;
				end
			end
			PH_START: begin
				st_next.pin_stb   = 1'b0;
				st_next.tx_shift  = byte_at(st.func, st.address, st.data_byte, st.byte_count);
				st_next.bit_count = 4'd0;
				st_next.phase     = PH_BIT_LO;
			end
			PH_BIT_LO: begin
				st_next.pin_clk  = 1'b0;
				st_next.pin_dat  = st.tx_shift[0];
				st_next.tx_shift = {1'b0, st.tx_shift[7:1]};
				st_next.phase    = PH_BIT_HI;
			end
			PH_BIT_HI: begin
				st_next.pin_clk   = 1'b1;
				st_next.bit_count = bit_inc;
				if (bit_inc < 4'd8) begin
					st_next.phase = PH_BIT_LO;
				end else if (st.func == FUNC_KEYS) begin
					st_next.wait_count = 4'd0;
					st_next.phase      = PH_SETTLE;
				end else if (gap || last_byte) begin
					st_next.phase = PH_STB_UP;
				end else begin
					st_next.byte_count = byte_inc;
					st_next.tx_shift   = byte_at(st.func, st.address, st.data_byte, byte_inc);
					st_next.bit_count  = 4'd0;
					st_next.phase      = PH_BIT_LO;
				end
			end
			PH_SETTLE: begin
				st_next.wait_count = wait_inc;
				if (wait_inc >= SETTLE_END) begin
					st_next.bit_count  = 4'd0;
					st_next.byte_count = 5'd0;
					st_next.phase      = PH_KEY_LO;
				end
			end
			PH_KEY_LO: begin
				st_next.pin_clk = 1'b0;
				st_next.pin_dat = 1'b1;
				if (st.bit_count < 4'd3 && st.byte_count < 5'd8) begin
					for (int i = 0; i < KEY_WIDTH; i++) begin
						if (key_pos == 5'(i))
							st_next.key_shift[i] = req.di;
					end
				end
				st_next.phase = PH_KEY_HI;
			end
			PH_KEY_HI: begin
				st_next.pin_clk = 1'b1;
				if (bit_inc >= 4'd4) begin
					st_next.bit_count  = 4'd0;
					st_next.byte_count = byte_inc;
					st_next.phase      = (byte_inc >= 5'd8) ? PH_STB_UP : PH_KEY_LO;
				end else begin
					st_next.bit_count = bit_inc;
					st_next.phase     = (st.byte_count >= 5'd8) ? PH_STB_UP : PH_KEY_LO;
				end
			end
			PH_STB_UP: begin
				st_next.pin_stb = 1'b1;
				if (st.func == FUNC_KEYS) begin
					keys_done     = 1'b1;
					st_next.phase = PH_IDLE;
				end else if (gap) begin
					st_next.phase = PH_GAP;
				end else begin
					st_next.phase = PH_IDLE;
				end
			end
			PH_GAP: begin
				if (last_byte) begin
					st_next.phase = PH_IDLE;
				end else begin
					st_next.byte_count = byte_inc;
					st_next.phase      = PH_START;
				end
			end
			default: st_next.phase = PH_IDLE;
		endcase
	end

	always_comb begin
		res.clk_pin    = st_next.pin_clk;
		res.data_pin   = st_next.pin_dat;
		res.strobe_pin = st_next.pin_stb;
		res.busy_res   = (st_next.phase != PH_IDLE);
		res.keys_valid = keys_done;
		res.keys       = keys_done ? st_next.key_shift : '0;
	end

endmodule

// ===== src/led_key_driver_serial_sequencer.sv =====
// Sequencer for a three-wire (strobe, clock, data) LED-driver and key-scan chip. Every
// accepted item is one pin-timing tick and yields exactly one result with the pin levels
// after that tick, a busy flag, and on the tick a key read ends the 24-bit key vector.
// A tick whose request bit is set starts a sequence only when idle; requests seen while
// busy are dropped. One item is taken per clock cycle: the request is registered, one
// pass of the sequencer logic updates the state and fills the result register, which
// drives the outputs until the result side takes it, and the rate drops only while the
// result side holds ready low.
`include "assert_macros.svh"

module led_key_driver_serial_sequencer #(
	parameter int CLEAR_BYTES  = lkd_pkg::CLEAR_BYTES_DEF,
	parameter int SETTLE_TICKS = lkd_pkg::SETTLE_TICKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	lkd_item_if.sink            item,
	lkd_result_if.source        result
);
	import lkd_pkg::*;

	localparam state_t ST_RESET = '{phase: PH_IDLE, pin_clk: 1'b1, pin_dat: 1'b1,
		pin_stb: 1'b1, default: '0};

	logic   valid_s1;
	req_t   req_s1;
	logic   valid_s2;
	res_t   res_s2;
	state_t st_q;
	state_t st_next;
	res_t   res_next;
	logic   adv;

	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			req_s1 <= {item.req_valid, item.func, item.address, item.data_byte, item.di};
		end
	end

	lkd_step #(
		.CLEAR_BYTES (CLEAR_BYTES),
		.SETTLE_TICKS(SETTLE_TICKS)
	) u_step (
		.st     (st_q),
		.req    (req_s1),
		.st_next(st_next),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (adv) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_next;
		end
	end

	assign result.valid      = valid_s2;
	assign result.clk_pin    = res_s2.clk_pin;
	assign result.data_pin   = res_s2.data_pin;
	assign result.strobe_pin = res_s2.strobe_pin;
	assign result.busy_res   = res_s2.busy_res;
	assign result.keys_valid = res_s2.keys_valid;
	assign result.keys       = res_s2.keys;

	`ASSERT_CLK(a_busy_tracks_state, valid_s2 |-> (res_s2.busy_res == (st_q.phase != PH_IDLE)), "busy flag disagrees with sequencer state")
	`ASSERT_CLK(a_keys_report, (adv && st_q.phase == PH_STB_UP && st_q.func == FUNC_KEYS) |=> (valid_s2 && res_s2.keys_valid), "key read end not reported")
	`ASSERT_CLK(a_idle_holds, (adv && st_q.phase == PH_IDLE && !req_s1.req_valid) |=> (st_q.phase == PH_IDLE), "left idle without a request")

endmodule
